FILE: rtl/bidir_dshot_telemetry_decoder_assert.svh
// Assertion macros for the telemetry decoder.
// Each expects signals named clock and reset in the module that uses it.
`ifndef BIDIR_DSHOT_TELEMETRY_DECODER_ASSERT_SVH
`define BIDIR_DSHOT_TELEMETRY_DECODER_ASSERT_SVH

// same-cycle implication
`define BDTD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BDTD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/bdtd_pkg.sv
package bdtd_pkg;

   localparam int STAMP_BITS   = 16;
   localparam int FRAME_BITS   = 21;
   localparam int COUNT_BITS   = 6;
   localparam int RUN_MAX      = (1 << COUNT_BITS) - 1;
   localparam int TPB_BITS     = 8;
   localparam int ERPM_BITS    = 20;
   localparam int RAW_BITS     = 16;
   localparam int STATUS_BITS  = 2;
   localparam int DIV_NUM_BITS = 20;
   localparam int DIV_DEN_BITS = 16;
   localparam int DIV_CNT_BITS = $clog2(DIV_NUM_BITS);
   localparam int RSP_FIELD_BITS = ERPM_BITS + STATUS_BITS + RAW_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam logic [DIV_NUM_BITS-1:0] ERPM_NUMERATOR = DIV_NUM_BITS'(1000000 * 60 / 100);
   localparam logic [TPB_BITS-1:0]     TPB_RESET      = TPB_BITS'(16);
   localparam logic [11:0]             DATA_ZERO_RPM  = 12'hfff;
   localparam logic [3:0]              CSUM_GOOD      = 4'hf;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FRAME  = 2'd1,
      STATUS_CSUM   = 2'd2,
      STATUS_PERIOD = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_RUN_DIV,
      ST_FILL,
      ST_DECODE,
      ST_ERPM,
      ST_ERPM_DIV,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic take_item;
      logic restart;
      logic start_run_div;
      logic run_append;
      logic fill;
      logic decode;
      logic start_erpm_div;
      logic load_result;
   } cmd_type;

   typedef struct packed {
      logic first;
      logic last;
      logic full;
      logic div_done;
      logic erpm_needed;
   } stat_type;

   // GCR quintet to nibble; codes with no meaning give zero
   function automatic logic [3:0] gcr_nibble(input logic [4:0] code);
      logic [3:0] nib;
      case (code)
         5'd9:    nib = 4'd9;
         5'd10:   nib = 4'd10;
         5'd11:   nib = 4'd11;
         5'd13:   nib = 4'd13;
         5'd14:   nib = 4'd14;
         5'd15:   nib = 4'd15;
         5'd18:   nib = 4'd2;
         5'd19:   nib = 4'd3;
         5'd21:   nib = 4'd5;
         5'd22:   nib = 4'd6;
         5'd23:   nib = 4'd7;
         5'd26:   nib = 4'd8;
         5'd27:   nib = 4'd1;
         5'd29:   nib = 4'd4;
         5'd30:   nib = 4'd12;
         default: nib = 4'd0;
      endcase
      return nib;
   endfunction

endpackage

FILE: rtl/bidir_dshot_telemetry_decoder.sv
// Channel  Dir  Width  Contents
// req      in   16     tdata timestamp, tuser first edge, tlast last edge
// rsp      out  40     tdata erpm, status, raw_word; one word per last edge
// csr      in   8      ticks_per_bit, reset value 16
//
// A non-first edge that is not ignored uses the shared divider to round the
// gap to a run length; first or ignored edges skip the divider.
// A last edge adds fill unless the frame is full, decode and, when erpm is
// needed, a second divide for erpm, plus any wait for the result register.
// Synchronous reset restores ticks_per_bit to 16 and clears the frame state.
// A result waiting in the output register does not block new edges until
// the next result is due.
`include "bidir_dshot_telemetry_decoder_assert.svh"

module bidir_dshot_telemetry_decoder (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [bdtd_pkg::STAMP_BITS-1:0]      req_tdata,  // [15:0] timestamp
   input  logic                                 req_tuser,  // [0] is_first
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [19:0] erpm, [21:20] status, [37:22] raw_word, [39:38] zero
   output logic [bdtd_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                 csr_tvalid,
   output logic                                 csr_tready,
   input  logic [bdtd_pkg::TPB_BITS-1:0]        csr_tdata   // [7:0] ticks_per_bit
);
   import bdtd_pkg::*;

   logic [TPB_BITS-1:0]      tpb_ff, tpb_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                     out_free;
   cmd_type                  cmd;
   stat_type                 stat;
   logic [ERPM_BITS-1:0]     erpm;
   status_type               status;
   logic [RAW_BITS-1:0]      raw_word;

   assign csr_tready = 1'b1;
   assign tpb_in     = (csr_tvalid && csr_tready) ? csr_tdata : tpb_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   bdtd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .out_free  (out_free),
      .stat      (stat),
      .req_ready (req_tready),
      .cmd       (cmd)
   );

   bdtd_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .stamp         (req_tdata),
      .is_first      (req_tuser),
      .is_last       (req_tlast),
      .ticks_per_bit (tpb_ff),
      .cmd           (cmd),
      .stat          (stat),
      .erpm          (erpm),
      .status        (status),
      .raw_word      (raw_word)
   );

   // hold the word until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_BITS'({raw_word, status, erpm});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tpb_ff       <= TPB_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         tpb_ff       <= tpb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `BDTD_ASSERT_NOW(a_load_into_free, cmd.load_result, out_free, "result overwrote an untaken word")
   `BDTD_ASSERT_NOW(a_err_zero_erpm, rsp_valid_ff && rsp_data_ff[21:20] != STATUS_OK, rsp_data_ff[19:0] == '0, "erpm nonzero on a failed frame")
   `BDTD_ASSERT_NOW(a_frame_err_raw, rsp_valid_ff && rsp_data_ff[21:20] == STATUS_FRAME, rsp_data_ff[37:22] == '0, "raw word kept on a frame error")
   `BDTD_ASSERT_NEXT(a_busy_after_take, cmd.take_item, !req_tready, "edge taken while one is in progress")

endmodule

FILE: rtl/bdtd_div.sv
module bdtd_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [bdtd_pkg::DIV_NUM_BITS-1:0]  num,
   input  logic [bdtd_pkg::DIV_DEN_BITS-1:0]  den,
   output logic                               done,
   output logic [bdtd_pkg::DIV_NUM_BITS-1:0]  quotient
);
   import bdtd_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DIV_DEN_BITS-1:0] rem_ff, rem_in;
   logic [DIV_DEN_BITS-1:0] den_ff, den_in;
   logic [DIV_NUM_BITS-1:0] quo_ff, quo_in;
   logic [DIV_DEN_BITS:0]   rem_sh;
   logic [DIV_DEN_BITS:0]   trial;
   logic                    fits;

   // one quotient bit a cycle, restoring
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DIV_NUM_BITS-1]};
      trial   = rem_sh - {1'b0, den_ff};
      fits    = ~trial[DIV_DEN_BITS];
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = den;
         quo_in  = num;
      end else if (busy_ff) begin
         rem_in = fits ? trial[DIV_DEN_BITS-1:0] : rem_sh[DIV_DEN_BITS-1:0];
         quo_in = {quo_ff[DIV_NUM_BITS-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(DIV_NUM_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/bdtd_ctrl.sv
module bdtd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               out_free,
   input  bdtd_pkg::stat_type stat,
   output logic               req_ready,
   output bdtd_pkg::cmd_type  cmd
);
   import bdtd_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_item = 1'b1;
               state_in      = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            if (stat.first) begin
               cmd.restart = 1'b1;
               state_in    = stat.last ? ST_FILL : ST_IDLE;
            end else if (stat.full) begin
               // frame complete: drop the edge, decode bits as they are
               state_in = stat.last ? ST_DECODE : ST_IDLE;
            end else begin
               cmd.start_run_div = 1'b1;
               state_in          = ST_RUN_DIV;
            end
         end
         ST_RUN_DIV: begin
            if (stat.div_done) begin
               cmd.run_append = 1'b1;
               state_in       = stat.last ? ST_FILL : ST_IDLE;
            end
         end
         ST_FILL: begin
            cmd.fill = 1'b1;
            state_in = ST_DECODE;
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = ST_ERPM;
         end
         ST_ERPM: begin
            if (stat.erpm_needed) begin
               cmd.start_erpm_div = 1'b1;
               state_in           = ST_ERPM_DIV;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_ERPM_DIV: begin
            if (stat.div_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               cmd.load_result = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/bdtd_datapath.sv
module bdtd_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [bdtd_pkg::STAMP_BITS-1:0]  stamp,
   input  logic                             is_first,
   input  logic                             is_last,
   input  logic [bdtd_pkg::TPB_BITS-1:0]    ticks_per_bit,
   input  bdtd_pkg::cmd_type                cmd,
   output bdtd_pkg::stat_type               stat,
   output logic [bdtd_pkg::ERPM_BITS-1:0]   erpm,
   output bdtd_pkg::status_type             status,
   output logic [bdtd_pkg::RAW_BITS-1:0]    raw_word
);
   import bdtd_pkg::*;

   logic [STAMP_BITS-1:0] stamp_ff;
   logic                  first_ff;
   logic                  last_ff;
   logic [STAMP_BITS-1:0] prev_ff, prev_in;
   logic [COUNT_BITS-1:0] bit_count_ff, bit_count_in;
   logic [FRAME_BITS-1:0] shift_ff, shift_in;
   logic                  run_error_ff, run_error_in;
   logic [RAW_BITS-1:0]   word_ff;
   status_type            status_ff;
   logic                  erpm_needed_ff;
   logic [DIV_DEN_BITS-1:0] period_ff;

   logic                    full;
   logic [TPB_BITS-1:0]     tpb_eff;
   logic [STAMP_BITS-1:0]   gap;
   logic                    div_start;
   logic [DIV_NUM_BITS-1:0] div_num;
   logic [DIV_DEN_BITS-1:0] div_den;
   logic                    div_done;
   logic [DIV_NUM_BITS-1:0] div_q;
   logic [COUNT_BITS-1:0]   run_len;
   logic [COUNT_BITS-1:0]   app_len;
   logic [FRAME_BITS-1:0]   app_shift;
   logic [COUNT_BITS:0]     app_sum;
   logic [COUNT_BITS-1:0]   app_count;
   logic [RAW_BITS-1:0]     dec_word;
   logic [3:0]              dec_csum;
   logic [DIV_DEN_BITS-1:0] dec_period;

   assign full    = bit_count_ff >= COUNT_BITS'(FRAME_BITS);
   assign tpb_eff = (ticks_per_bit == '0) ? TPB_BITS'(1) : ticks_per_bit;
   assign gap     = stamp_ff - prev_ff;

   // shared divider: run rounding, then erpm
   always_comb begin
      div_start = cmd.start_run_div | cmd.start_erpm_div;
      if (cmd.start_erpm_div) begin
         div_num = ERPM_NUMERATOR + DIV_NUM_BITS'(period_ff >> 1);
         div_den = period_ff;
      end else begin
         div_num = DIV_NUM_BITS'(gap) + DIV_NUM_BITS'(tpb_eff >> 1);
         div_den = DIV_DEN_BITS'(tpb_eff);
      end
   end

   bdtd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   // append a one followed by len-1 zeros, saturate the count
   always_comb begin
      run_len   = (div_q > DIV_NUM_BITS'(RUN_MAX)) ? COUNT_BITS'(RUN_MAX)
                                                   : div_q[COUNT_BITS-1:0];
      app_len   = cmd.fill ? (COUNT_BITS'(FRAME_BITS) - bit_count_ff) : run_len;
      app_shift = (shift_ff << app_len) | (FRAME_BITS'(1) << (app_len - 1'b1));
      app_sum   = {1'b0, bit_count_ff} + {1'b0, app_len};
      app_count = (app_sum > (COUNT_BITS + 1)'(RUN_MAX)) ? COUNT_BITS'(RUN_MAX)
                                                         : app_sum[COUNT_BITS-1:0];
   end

   always_comb begin
      prev_in      = prev_ff;
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      run_error_in = run_error_ff;
      if (cmd.restart) begin
         prev_in      = stamp_ff;
         bit_count_in = '0;
         shift_in     = '0;
         run_error_in = 1'b0;
      end
      if (cmd.start_run_div) begin
         prev_in = stamp_ff;
      end
      if (cmd.run_append) begin
         if (div_q == '0) begin
            run_error_in = 1'b1;
         end else begin
            shift_in     = app_shift;
            bit_count_in = app_count;
         end
      end
      if (cmd.fill && !full) begin
         shift_in     = app_shift;
         bit_count_in = app_count;
      end
   end

   always_comb begin
      dec_word   = {gcr_nibble(shift_ff[19:15]), gcr_nibble(shift_ff[14:10]),
                    gcr_nibble(shift_ff[9:5]), gcr_nibble(shift_ff[4:0])};
      dec_csum   = dec_word[15:12] ^ dec_word[11:8] ^ dec_word[7:4] ^ dec_word[3:0];
      dec_period = DIV_DEN_BITS'(dec_word[12:4]) << dec_word[15:13];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff        <= '0;
         bit_count_ff   <= '0;
         shift_ff       <= '0;
         run_error_ff   <= 1'b0;
         erpm_needed_ff <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         bit_count_ff <= bit_count_in;
         shift_ff     <= shift_in;
         run_error_ff <= run_error_in;
         if (cmd.decode) begin
            erpm_needed_ff <= (bit_count_ff == COUNT_BITS'(FRAME_BITS)) && !run_error_ff &&
                              (dec_csum == CSUM_GOOD) && (dec_word[15:4] != DATA_ZERO_RPM) &&
                              (dec_word[12:4] != '0);
         end
      end
      if (cmd.take_item) begin
         stamp_ff <= stamp;
         first_ff <= is_first;
         last_ff  <= is_last;
      end
      if (cmd.decode) begin
         period_ff <= dec_period;
         if (bit_count_ff != COUNT_BITS'(FRAME_BITS) || run_error_ff) begin
            status_ff <= STATUS_FRAME;
            word_ff   <= '0;
         end else if (dec_csum != CSUM_GOOD) begin
            status_ff <= STATUS_CSUM;
            word_ff   <= dec_word;
         end else if (dec_word[15:4] == DATA_ZERO_RPM) begin
            status_ff <= STATUS_OK;
            word_ff   <= dec_word;
         end else if (dec_word[12:4] == '0) begin
            status_ff <= STATUS_PERIOD;
            word_ff   <= dec_word;
         end else begin
            status_ff <= STATUS_OK;
            word_ff   <= dec_word;
         end
      end
   end

   always_comb begin
      stat.first       = first_ff;
      stat.last        = last_ff;
      stat.full        = full;
      stat.div_done    = div_done;
      stat.erpm_needed = erpm_needed_ff;
   end

   assign erpm     = erpm_needed_ff ? div_q[ERPM_BITS-1:0] : '0;
   assign status   = status_ff;
   assign raw_word = word_ff;

endmodule

FILE: test/tb_top.sv
module tb_top;
   import bdtd_pkg::*;

   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_ITEMS   = 333;
   localparam int CFG_SPACING   = 110;

   // quintet to nibble, codes with no meaning give zero
   localparam logic [3:0] QUINTET_MAP [32] = '{
      4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
      4'd0, 4'd9, 4'd10, 4'd11, 4'd0, 4'd13, 4'd14, 4'd15,
      4'd0, 4'd0, 4'd2, 4'd3, 4'd0, 4'd5, 4'd6, 4'd7,
      4'd0, 4'd0, 4'd8, 4'd1, 4'd0, 4'd4, 4'd12, 4'd0
   };
   localparam logic [4:0] NIBBLE_CODE [16] = '{
      5'h19, 5'h1b, 5'h12, 5'h13, 5'h1d, 5'h15, 5'h16, 5'h17,
      5'h1a, 5'h09, 5'h0a, 5'h0b, 5'h1e, 5'h0d, 5'h0e, 5'h0f
   };
   localparam logic [TPB_BITS-1:0] TICK_PLAN [8] = '{
      8'd16, 8'd1, 8'd255, 8'd0, 8'd100, 8'd7, 8'd200, 8'd16
   };

   typedef struct packed {
      logic [ERPM_BITS-1:0] erpm;
      status_type           status;
      logic [RAW_BITS-1:0]  raw;
   } telemetry_t;

   typedef struct {
      logic [STAMP_BITS-1:0] stamp;
      bit                    first;
      bit                    last;
   } edge_item_t;

   typedef struct {
      bit                    csr;
      logic [STAMP_BITS-1:0] value;
      bit                    first;
      bit                    last;
      bit                    typed;
      status_type            status;
      logic [RAW_BITS-1:0]   raw;
   } vector_t;

   // csr rows write ticks_per_bit; typed rows carry their own expected word
   vector_t directed_list [22] = '{
      '{0, 16'h0000, 1, 1, 1, STATUS_CSUM,  16'h0000},
      '{0, 16'd100,  1, 0, 0, STATUS_OK,    16'h0000},
      '{0, 16'd100,  0, 1, 1, STATUS_FRAME, 16'h0000},
      '{0, 16'h0000, 1, 0, 0, STATUS_OK,    16'h0000},
      '{0, 16'hffff, 0, 1, 1, STATUS_FRAME, 16'h0000},
      '{0, 16'hfff0, 1, 0, 0, STATUS_OK,    16'h0000},
      '{0, 16'h0010, 0, 0, 0, STATUS_OK,    16'h0000},
      '{0, 16'h0140, 0, 1, 0, STATUS_OK,    16'h0000},
      '{0, 16'd1000, 1, 0, 0, STATUS_OK,    16'h0000},
      '{0, 16'd1336, 0, 0, 0, STATUS_OK,    16'h0000},
      '{0, 16'd1400, 0, 0, 0, STATUS_OK,    16'h0000},
      '{0, 16'd2000, 0, 1, 1, STATUS_CSUM,  16'h0000},
      '{0, 16'd3000, 0, 1, 0, STATUS_OK,    16'h0000},
      '{1, 16'd0,    0, 0, 0, STATUS_OK,    16'h0000},
      '{0, 16'd5,    1, 0, 0, STATUS_OK,    16'h0000},
      '{0, 16'd8,    0, 0, 0, STATUS_OK,    16'h0000},
      '{0, 16'd26,   0, 1, 0, STATUS_OK,    16'h0000},
      '{1, 16'd255,  0, 0, 0, STATUS_OK,    16'h0000},
      '{0, 16'h8000, 1, 0, 0, STATUS_OK,    16'h0000},
      '{0, 16'h807f, 0, 0, 0, STATUS_OK,    16'h0000},
      '{0, 16'h80ff, 0, 1, 1, STATUS_FRAME, 16'h0000},
      '{1, 16'd16,   0, 0, 0, STATUS_OK,    16'h0000}
   };

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [STAMP_BITS-1:0]    req_tdata = '0;
   logic                     req_tuser = 1'b0;
   logic                     req_tlast = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_tvalid = 1'b0;
   logic                     csr_tready;
   logic [TPB_BITS-1:0]      csr_tdata = '0;

   // decoder copy
   logic [TPB_BITS-1:0]   tick_div = TPB_RESET;
   logic [STAMP_BITS-1:0] last_stamp = '0;
   int                    bits_seen = 0;
   logic [FRAME_BITS-1:0] gathered = '0;
   bit                    run_bad = 1'b0;

   telemetry_t readings_due[$];
   int         items_sent = 0;
   int         mismatches = 0;
   int         snd_idle = 0;
   int         rcv_idle = 0;
   int         plan_pos = 0;

   bidir_dshot_telemetry_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic shift_in_run(input int len);
      logic [63:0] v;
      v = (64'(gathered) << len) | (64'd1 << (len - 1));
      gathered = v[FRAME_BITS-1:0];
      bits_seen = (bits_seen + len > RUN_MAX) ? RUN_MAX : bits_seen + len;
   endtask

   function automatic telemetry_t decode_gathered();
      telemetry_t       r;
      logic [15:0]      word;
      logic [3:0]       csum;
      logic [11:0]      data;
      int unsigned      period;
      r = '0;
      if (bits_seen != FRAME_BITS || run_bad) begin
         r.status = STATUS_FRAME;
         return r;
      end
      for (int q = 0; q < 4; q++)
         word[4*q +: 4] = QUINTET_MAP[gathered[5*q +: 5]];
      r.raw = word;
      csum = word[3:0] ^ word[7:4] ^ word[11:8] ^ word[15:12];
      if (csum != CSUM_GOOD) begin
         r.status = STATUS_CSUM;
         return r;
      end
      data = word[15:4];
      if (data == DATA_ZERO_RPM)
         return r;
      period = 32'(data[8:0]) << data[11:9];
      if (period == 0) begin
         r.status = STATUS_PERIOD;
         return r;
      end
      r.erpm = ERPM_BITS'((32'(ERPM_NUMERATOR) + period / 2) / period);
      return r;
   endfunction

   task automatic track_edge(input edge_item_t e, output bit produced, output telemetry_t res);
      bit                    skipped;
      int unsigned           t;
      int unsigned           len;
      logic [STAMP_BITS-1:0] gap;
      skipped = 1'b0;
      produced = 1'b0;
      res = '0;
      if (e.first) begin
         bits_seen = 0;
         gathered = '0;
         run_bad = 1'b0;
         last_stamp = e.stamp;
      end else if (bits_seen >= FRAME_BITS) begin
         skipped = 1'b1;
      end else begin
         t = (tick_div == 0) ? 1 : tick_div;
         gap = e.stamp - last_stamp;
         len = (32'(gap) + t / 2) / t;
         last_stamp = e.stamp;
         if (len == 0)
            run_bad = 1'b1;
         else
            shift_in_run((len > RUN_MAX) ? RUN_MAX : len);
      end
      if (e.last) begin
         if (!skipped && bits_seen < FRAME_BITS)
            shift_in_run(FRAME_BITS - bits_seen);
         res = decode_gathered();
         produced = 1'b1;
      end
   endtask

   task automatic send_edge(input edge_item_t e, input bit typed, input telemetry_t typed_res);
      bit         produced;
      telemetry_t res;
      while ($urandom_range(0, 99) < snd_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= e.stamp;
      req_tuser <= e.first;
      req_tlast <= e.last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      track_edge(e, produced, res);
      if (produced)
         readings_due.push_back(typed ? typed_res : res);
      items_sent++;
   endtask

   // hold off until every word is back and the last edge has been digested
   task automatic drain();
      req_tvalid <= 1'b0;
      while (readings_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_tick_div(input logic [TPB_BITS-1:0] v);
      drain();
      csr_tvalid <= 1'b1;
      csr_tdata <= v;
      @(posedge clock);
      while (!csr_tready) @(posedge clock);
      csr_tvalid <= 1'b0;
      tick_div = v;
   endtask

   function automatic logic [TPB_BITS-1:0] next_tick_div();
      plan_pos++;
      if (plan_pos <= 8)
         return TICK_PLAN[plan_pos-1];
      return TPB_BITS'($urandom_range(0, 255));
   endfunction

   function automatic logic [STAMP_BITS-1:0] gap_for(input int r);
      int unsigned t;
      t = (tick_div == 0) ? 1 : tick_div;
      if (r == 0)
         return STAMP_BITS'($urandom_range(0, (t - 1) / 2));
      return STAMP_BITS'(r * t - t / 2 + $urandom_range(0, t - 1));
   endfunction

   function automatic logic [11:0] pick_data();
      case ($urandom_range(0, 9))
         0:       return DATA_ZERO_RPM;
         1:       return {3'($urandom_range(0, 7)), 9'd0};
         2:       return {3'd0, 9'd1};
         3:       return {3'd7, 9'h1ff};
         default: return 12'($urandom_range(0, 4095));
      endcase
   endfunction

   task automatic play_frame(input bit broken);
      logic [11:0]           data;
      logic [3:0]            csum;
      logic [15:0]           word;
      logic [FRAME_BITS-1:0] pattern;
      logic [STAMP_BITS-1:0] stamp;
      int                    runs[$];
      edge_item_t            seq[$];
      int                    prev;
      int                    measured;
      int                    k;
      int                    flaw;
      data = pick_data();
      csum = CSUM_GOOD ^ data[3:0] ^ data[7:4] ^ data[11:8];
      if ($urandom_range(0, 7) == 0)
         csum = csum ^ 4'($urandom_range(1, 15));
      word = {data, csum};
      pattern = '0;
      pattern[FRAME_BITS-1] = 1'b1;
      for (int q = 0; q < 4; q++)
         pattern[5*q +: 5] = NIBBLE_CODE[word[4*q +: 4]];
      // split the pattern into runs, each a one and its trailing zeros
      prev = FRAME_BITS - 1;
      for (int i = FRAME_BITS - 2; i >= 0; i--)
         if (pattern[i]) begin
            runs.push_back(prev - i);
            prev = i;
         end
      runs.push_back(prev + 1);
      flaw = broken ? $urandom_range(0, 4) : -1;
      k = $urandom_range(0, runs.size() - 1);
      case (flaw)
         0: runs[k] = 0;
         1: runs[k] = $urandom_range(22, 255);
         2: runs[k] = runs[k] + 1;
         3: runs[k] = (runs[k] > 1) ? runs[k] - 1 : runs[k] + 2;
         default: ;
      endcase
      // measure the final run too now and then, leaving nothing to fill
      measured = ($urandom_range(0, 3) == 0) ? runs.size() : runs.size() - 1;
      stamp = STAMP_BITS'($urandom_range(0, 65535));
      seq.push_back('{stamp, 1'b1, 1'b0});
      for (int i = 0; i < measured; i++) begin
         stamp = stamp + gap_for(runs[i]);
         seq.push_back('{stamp, 1'b0, 1'b0});
      end
      if ($urandom_range(0, 5) == 0)
         repeat ($urandom_range(1, 3)) begin
            stamp = stamp + STAMP_BITS'($urandom_range(0, 4000));
            seq.push_back('{stamp, 1'b0, 1'b0});
         end
      if (flaw == 4)
         seq[0].first = 1'b0;
      seq[seq.size()-1].last = 1'b1;
      foreach (seq[i])
         send_edge(seq[i], 1'b0, '0);
   endtask

   task automatic play_noise();
      edge_item_t e;
      repeat ($urandom_range(1, 4)) begin
         e.stamp = STAMP_BITS'($urandom_range(0, 65535));
         e.first = ($urandom_range(0, 3) == 0);
         e.last = ($urandom_range(0, 2) == 0);
         send_edge(e, 1'b0, '0);
      end
   endtask

   task automatic check_reading(input logic [RSP_DATA_BITS-1:0] word);
      telemetry_t want;
      logic [ERPM_BITS-1:0]   got_erpm;
      logic [STATUS_BITS-1:0] got_status;
      logic [RAW_BITS-1:0]    got_raw;
      got_erpm = word[ERPM_BITS-1:0];
      got_status = word[ERPM_BITS +: STATUS_BITS];
      got_raw = word[ERPM_BITS+STATUS_BITS +: RAW_BITS];
      if (readings_due.size() == 0) begin
         $error("unexpected result word %h", word);
         mismatches++;
         return;
      end
      want = readings_due.pop_front();
      if (got_erpm != want.erpm) begin
         $error("erpm expected %0d got %0d", want.erpm, got_erpm);
         mismatches++;
      end
      if (got_status != want.status) begin
         $error("status expected %0d got %0d", want.status, got_status);
         mismatches++;
      end
      if (got_raw != want.raw) begin
         $error("raw_word expected %h got %h", want.raw, got_raw);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_reading(rsp_tdata);
      rsp_tready <= ($urandom_range(0, 99) >= rcv_idle);
   end

   initial begin
      int         goal;
      int         next_cfg;
      int         pick;
      edge_item_t e;
      telemetry_t typed_res;
      snd_idle = 26;
      rcv_idle = 79;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_list[i]) begin
         if (directed_list[i].csr) begin
            write_tick_div(directed_list[i].value[TPB_BITS-1:0]);
         end else begin
            e = '{directed_list[i].value, directed_list[i].first, directed_list[i].last};
            typed_res = '{erpm: '0, status: directed_list[i].status,
                          raw: directed_list[i].raw};
            send_edge(e, directed_list[i].typed, typed_res);
         end
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin snd_idle = 26; rcv_idle = 79; end
            1: begin snd_idle = 79; rcv_idle = 26; end
            default: begin snd_idle = 0; rcv_idle = 0; end
         endcase
         write_tick_div(next_tick_div());
         goal = items_sent + PHASE_ITEMS;
         next_cfg = items_sent + CFG_SPACING;
         while (items_sent < goal) begin
            if (items_sent >= next_cfg) begin
               write_tick_div(next_tick_div());
               next_cfg += CFG_SPACING;
            end
            pick = $urandom_range(0, 99);
            if (pick < 3)
               drain();
            if (pick < 70)
               play_frame(1'b0);
            else if (pick < 85)
               play_frame(1'b1);
            else
               play_noise();
         end
      end

      req_tvalid <= 1'b0;
      while (readings_due.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
